FILE: sv/rrps_pkg.sv
// rrps_pkg: shared types, constants and helpers for the round-robin scheduler
// no dependencies; used by rrps_seq and round_robin_process_scheduler
package rrps_pkg;

    localparam int MAX_TASKS   = 8;
    localparam int QUEUE_DEPTH = 8;

    localparam int TID_W   = 3;
    localparam int CFG_W   = 4;
    localparam int ST_W    = 2;
    localparam int TADDR_W = $clog2(MAX_TASKS);
    localparam int NCNT_W  = $clog2(MAX_TASKS + 1);
    localparam int QP_W    = $clog2(QUEUE_DEPTH);
    localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int QADDR_W = QP_W + 1;
    localparam int QRAM_DEPTH = 2 ** QADDR_W;

    typedef logic [TID_W-1:0]   t_tid;
    typedef logic [CFG_W-1:0]   t_cfg;
    typedef logic [TADDR_W-1:0] t_taddr;
    typedef logic [NCNT_W-1:0]  t_ncnt;
    typedef logic [QP_W-1:0]    t_qptr;
    typedef logic [QC_W-1:0]    t_qcnt;
    typedef logic [QADDR_W-1:0] t_qaddr;

    typedef enum logic [ST_W-1:0] {
        TS_READY    = 2'd0,
        TS_RUNNING  = 2'd1,
        TS_BLOCKED  = 2'd2,
        TS_FINISHED = 2'd3
    } t_tstate;

    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_SLICE    = 3'd1;
    localparam logic [2:0] OP_IO_DONE  = 3'd2;
    localparam logic [2:0] OP_SYSCALL  = 3'd3;
    localparam logic [2:0] OP_FINISH   = 3'd4;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    // upper address bit of the shared queue memory selects the queue
    localparam logic QSEL_READY   = 1'b0;
    localparam logic QSEL_BLOCKED = 1'b1;

    localparam t_cfg TASK_COUNT_RESET = 4'd3;

    typedef struct packed {
        logic [2:0] operation;
        t_tid       task_id;
    } t_in_req;

    typedef struct packed {
        logic       stop_valid;
        t_tid       stop_id;
        logic       dispatch_valid;
        t_tid       dispatch_id;
        logic       running_valid;
        t_tid       running_id;
        logic [1:0] status;
        logic       all_finished;
    } t_out_rsp;

    typedef struct packed {
        logic            we;
        t_taddr          waddr;
        logic [ST_W-1:0] wdata;
        t_taddr          raddr;
    } t_tram_req;

    typedef struct packed {
        logic   we;
        t_qaddr waddr;
        t_tid   wdata;
        t_qaddr raddr;
    } t_qram_req;

    function automatic t_qptr q_next(t_qptr p);
        return (p == t_qptr'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

FILE: sv/rrps_ram.sv
// rrps_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies
module rrps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: sv/rrps_seq.sv
// rrps_seq: scheduler sequencer, reads, modifies and writes back the task
// state ram and the shared ready/blocked queue ram; depends on rrps_pkg
module rrps_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rrps_pkg::t_in_req     i_in,
    input  rrps_pkg::t_cfg        i_task_count,
    output rrps_pkg::t_tram_req   o_tram,
    input  logic [rrps_pkg::ST_W-1:0] i_tram_rdata,
    output rrps_pkg::t_qram_req   o_qram,
    input  rrps_pkg::t_tid        i_qram_rdata,
    output logic                  o_done,
    input  logic                  i_done_ready,
    output rrps_pkg::t_out_rsp    o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_TCHK, S_IO_RD, S_IO_CHK, S_SCAN, S_DISP, S_DRD, S_DCHK, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_op, n_op;
    rrps_pkg::t_tid r_id, n_id;
    logic [rrps_pkg::MAX_TASKS-1:0] r_tvalid, n_tvalid;
    rrps_pkg::t_taddr r_taddr;
    rrps_pkg::t_qptr r_rhead, n_rhead, r_rtail, n_rtail;
    rrps_pkg::t_qcnt r_rcnt, n_rcnt;
    rrps_pkg::t_qptr r_bhead, n_bhead, r_btail, n_btail;
    rrps_pkg::t_qcnt r_bcnt, n_bcnt;
    logic r_cur_v, n_cur_v;
    rrps_pkg::t_tid r_cur, n_cur;
    rrps_pkg::t_ncnt r_live, n_live;
    rrps_pkg::t_tid r_put_id, n_put_id;
    rrps_pkg::t_qptr r_scan_ptr, n_scan_ptr;
    rrps_pkg::t_qcnt r_scan_cnt, n_scan_cnt;
    logic r_pend, n_pend;
    rrps_pkg::t_qcnt r_fill, n_fill;
    logic [1:0] r_status, n_status;
    logic r_stop_v, n_stop_v;
    rrps_pkg::t_tid r_stop_id, n_stop_id;
    logic r_disp_v, n_disp_v;
    rrps_pkg::t_tid r_disp_id, n_disp_id;

    rrps_pkg::t_ncnt n_act;
    rrps_pkg::t_qcnt n_fill_to;
    rrps_pkg::t_tstate rd_state;
    rrps_pkg::t_ncnt live_dec;
    logic cur_keep;
    logic scan_hit;

    // tasks in use, clamped to the table size
    assign n_act = (i_task_count > rrps_pkg::t_cfg'(rrps_pkg::MAX_TASKS))
                 ? rrps_pkg::t_ncnt'(rrps_pkg::MAX_TASKS)
                 : rrps_pkg::t_ncnt'(i_task_count);
    assign n_fill_to = (n_act > rrps_pkg::t_ncnt'(rrps_pkg::QUEUE_DEPTH))
                     ? rrps_pkg::t_qcnt'(rrps_pkg::QUEUE_DEPTH)
                     : rrps_pkg::t_qcnt'(n_act);

    // an entry never written since start reads as ready
    assign rd_state = r_tvalid[r_taddr] ? rrps_pkg::t_tstate'(i_tram_rdata)
                                        : rrps_pkg::TS_READY;
    assign live_dec = (r_live != '0) ? r_live - 1'b1 : '0;
    assign cur_keep = r_cur_v && (r_cur != r_id);
    assign scan_hit = r_pend && (i_qram_rdata == r_put_id);

    assign o_in_ready = (r_state == S_IDLE);
    assign o_done     = (r_state == S_FIN);

    always_comb begin
        o_rsp.stop_valid     = r_stop_v;
        o_rsp.stop_id        = r_stop_id;
        o_rsp.dispatch_valid = r_disp_v;
        o_rsp.dispatch_id    = r_disp_id;
        o_rsp.running_valid  = r_cur_v;
        o_rsp.running_id     = r_cur_v ? r_cur : '0;
        o_rsp.status         = r_status;
        o_rsp.all_finished   = (r_live == '0);
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_id       = r_id;
        n_tvalid   = r_tvalid;
        n_rhead    = r_rhead;
        n_rtail    = r_rtail;
        n_rcnt     = r_rcnt;
        n_bhead    = r_bhead;
        n_btail    = r_btail;
        n_bcnt     = r_bcnt;
        n_cur_v    = r_cur_v;
        n_cur      = r_cur;
        n_live     = r_live;
        n_put_id   = r_put_id;
        n_scan_ptr = r_scan_ptr;
        n_scan_cnt = r_scan_cnt;
        n_pend     = r_pend;
        n_fill     = r_fill;
        n_status   = r_status;
        n_stop_v   = r_stop_v;
        n_stop_id  = r_stop_id;
        n_disp_v   = r_disp_v;
        n_disp_id  = r_disp_id;

        o_tram.we    = 1'b0;
        o_tram.waddr = rrps_pkg::t_taddr'(r_id);
        o_tram.wdata = rrps_pkg::TS_READY;
        o_tram.raddr = rrps_pkg::t_taddr'(i_in.task_id);
        o_qram.we    = 1'b0;
        o_qram.waddr = {rrps_pkg::QSEL_READY, r_rtail};
        o_qram.wdata = r_put_id;
        o_qram.raddr = {rrps_pkg::QSEL_READY, r_rhead};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_in.operation;
                    n_id      = i_in.task_id;
                    n_status  = rrps_pkg::STAT_DONE;
                    n_stop_v  = 1'b0;
                    n_stop_id = '0;
                    n_disp_v  = 1'b0;
                    n_disp_id = '0;
                    case (i_in.operation)
                        rrps_pkg::OP_START: begin
                            n_tvalid = '0;
                            n_rhead  = '0;
                            n_rtail  = '0;
                            n_rcnt   = '0;
                            n_bhead  = '0;
                            n_btail  = '0;
                            n_bcnt   = '0;
                            n_cur_v  = 1'b0;
                            n_cur    = '0;
                            n_live   = n_act;
                            n_fill   = '0;
                            if (n_act > rrps_pkg::t_ncnt'(rrps_pkg::QUEUE_DEPTH)) begin
                                n_status = rrps_pkg::STAT_FULL;
                            end
                            n_state = S_FILL;
                        end
                        rrps_pkg::OP_SLICE: begin
                            if (r_cur_v) begin
                                o_tram.we    = 1'b1;
                                o_tram.waddr = rrps_pkg::t_taddr'(r_cur);
                                o_tram.wdata = rrps_pkg::TS_READY;
                                n_tvalid[rrps_pkg::t_taddr'(r_cur)] = 1'b1;
                                n_stop_v   = 1'b1;
                                n_stop_id  = r_cur;
                                n_cur_v    = 1'b0;
                                n_cur      = '0;
                                n_put_id   = r_cur;
                                n_scan_ptr = r_rhead;
                                n_scan_cnt = '0;
                                n_pend     = 1'b0;
                                if (rrps_pkg::t_ncnt'(r_cur) >= n_act) begin
                                    n_state = S_DISP;
                                end else begin
                                    n_state = S_SCAN;
                                end
                            end else begin
                                n_state = S_DISP;
                            end
                        end
                        rrps_pkg::OP_IO_DONE: begin
                            if (r_bcnt == '0) begin
                                n_status = rrps_pkg::STAT_IGNORED;
                                n_state  = S_FIN;
                            end else begin
                                o_qram.raddr = {rrps_pkg::QSEL_BLOCKED, r_bhead};
                                n_bhead = rrps_pkg::q_next(r_bhead);
                                n_bcnt  = r_bcnt - 1'b1;
                                n_state = S_IO_RD;
                            end
                        end
                        rrps_pkg::OP_SYSCALL, rrps_pkg::OP_FINISH: begin
                            if (rrps_pkg::t_ncnt'(i_in.task_id) >= n_act) begin
                                n_status = rrps_pkg::STAT_UNKNOWN;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_TCHK;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            // write task ids 0 .. up into the ready queue, one a cycle
            S_FILL: begin
                if (r_fill < n_fill_to) begin
                    o_qram.we    = 1'b1;
                    o_qram.waddr = {rrps_pkg::QSEL_READY, rrps_pkg::t_qptr'(r_fill)};
                    o_qram.wdata = rrps_pkg::t_tid'(r_fill);
                    n_fill = r_fill + 1'b1;
                end else begin
                    n_rcnt  = n_fill_to;
                    n_rtail = (n_fill_to == rrps_pkg::t_qcnt'(rrps_pkg::QUEUE_DEPTH))
                            ? '0 : rrps_pkg::t_qptr'(n_fill_to);
                    n_state = S_DISP;
                end
            end

            S_TCHK: begin
                if (rd_state == rrps_pkg::TS_FINISHED) begin
                    n_status = rrps_pkg::STAT_UNKNOWN;
                    n_state  = S_FIN;
                end else if (r_op == rrps_pkg::OP_SYSCALL) begin
                    if (r_bcnt >= rrps_pkg::t_qcnt'(rrps_pkg::QUEUE_DEPTH)) begin
                        n_status = rrps_pkg::STAT_FULL;
                        n_state  = S_FIN;
                    end else begin
                        o_tram.we    = 1'b1;
                        o_tram.wdata = rrps_pkg::TS_BLOCKED;
                        n_tvalid[rrps_pkg::t_taddr'(r_id)] = 1'b1;
                        o_qram.we    = 1'b1;
                        o_qram.waddr = {rrps_pkg::QSEL_BLOCKED, r_btail};
                        o_qram.wdata = r_id;
                        n_btail   = rrps_pkg::q_next(r_btail);
                        n_bcnt    = r_bcnt + 1'b1;
                        n_stop_v  = 1'b1;
                        n_stop_id = r_id;
                        n_cur_v   = cur_keep;
                        n_cur     = cur_keep ? r_cur : '0;
                        n_state   = cur_keep ? S_FIN : S_DISP;
                    end
                end else begin
                    o_tram.we    = 1'b1;
                    o_tram.wdata = rrps_pkg::TS_FINISHED;
                    n_tvalid[rrps_pkg::t_taddr'(r_id)] = 1'b1;
                    n_live  = live_dec;
                    n_cur_v = cur_keep;
                    n_cur   = cur_keep ? r_cur : '0;
                    n_state = (live_dec != '0 && !cur_keep) ? S_DISP : S_FIN;
                end
            end

            S_IO_RD: begin
                o_tram.raddr = rrps_pkg::t_taddr'(i_qram_rdata);
                n_put_id     = i_qram_rdata;
                n_state      = S_IO_CHK;
            end

            S_IO_CHK: begin
                if (rd_state == rrps_pkg::TS_BLOCKED) begin
                    o_tram.we    = 1'b1;
                    o_tram.waddr = rrps_pkg::t_taddr'(r_put_id);
                    o_tram.wdata = rrps_pkg::TS_READY;
                    n_tvalid[rrps_pkg::t_taddr'(r_put_id)] = 1'b1;
                    n_scan_ptr = r_rhead;
                    n_scan_cnt = '0;
                    n_pend     = 1'b0;
                    if (rrps_pkg::t_ncnt'(r_put_id) >= n_act) begin
                        n_state = r_cur_v ? S_FIN : S_DISP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else begin
                    // stale or finished entry is dropped
                    n_state = S_FIN;
                end
            end

            // duplicate search: one read issued and one compare per cycle
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = r_cur_v ? S_FIN : S_DISP;
                end else if (r_scan_cnt < r_rcnt) begin
                    o_qram.raddr = {rrps_pkg::QSEL_READY, r_scan_ptr};
                    n_scan_ptr   = rrps_pkg::q_next(r_scan_ptr);
                    n_scan_cnt   = r_scan_cnt + 1'b1;
                    n_pend       = 1'b1;
                end else begin
                    if (r_rcnt >= rrps_pkg::t_qcnt'(rrps_pkg::QUEUE_DEPTH)) begin
                        n_status = rrps_pkg::STAT_FULL;
                    end else begin
                        o_qram.we = 1'b1;
                        n_rtail   = rrps_pkg::q_next(r_rtail);
                        n_rcnt    = r_rcnt + 1'b1;
                    end
                    n_state = r_cur_v ? S_FIN : S_DISP;
                end
            end

            S_DISP: begin
                if (r_rcnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_rhead = rrps_pkg::q_next(r_rhead);
                    n_rcnt  = r_rcnt - 1'b1;
                    n_state = S_DRD;
                end
            end

            S_DRD: begin
                o_tram.raddr = rrps_pkg::t_taddr'(i_qram_rdata);
                n_put_id     = i_qram_rdata;
                n_state      = S_DCHK;
            end

            // skip entries whose task left the ready state
            S_DCHK: begin
                if (rd_state == rrps_pkg::TS_READY) begin
                    o_tram.we    = 1'b1;
                    o_tram.waddr = rrps_pkg::t_taddr'(r_put_id);
                    o_tram.wdata = rrps_pkg::TS_RUNNING;
                    n_tvalid[rrps_pkg::t_taddr'(r_put_id)] = 1'b1;
                    n_cur_v   = 1'b1;
                    n_cur     = r_put_id;
                    n_disp_v  = 1'b1;
                    n_disp_id = r_put_id;
                    n_state   = S_FIN;
                end else begin
                    n_state = S_DISP;
                end
            end

            S_FIN: begin
                if (i_done_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_op       <= rrps_pkg::OP_START;
            r_id       <= '0;
            r_tvalid   <= '0;
            r_taddr    <= '0;
            r_rhead    <= '0;
            r_rtail    <= '0;
            r_rcnt     <= '0;
            r_bhead    <= '0;
            r_btail    <= '0;
            r_bcnt     <= '0;
            r_cur_v    <= 1'b0;
            r_cur      <= '0;
            r_live     <= '0;
            r_put_id   <= '0;
            r_scan_ptr <= '0;
            r_scan_cnt <= '0;
            r_pend     <= 1'b0;
            r_fill     <= '0;
            r_status   <= rrps_pkg::STAT_DONE;
            r_stop_v   <= 1'b0;
            r_stop_id  <= '0;
            r_disp_v   <= 1'b0;
            r_disp_id  <= '0;
        end else begin
            r_state    <= n_state;
            r_op       <= n_op;
            r_id       <= n_id;
            r_tvalid   <= n_tvalid;
            r_taddr    <= o_tram.raddr;
            r_rhead    <= n_rhead;
            r_rtail    <= n_rtail;
            r_rcnt     <= n_rcnt;
            r_bhead    <= n_bhead;
            r_btail    <= n_btail;
            r_bcnt     <= n_bcnt;
            r_cur_v    <= n_cur_v;
            r_cur      <= n_cur;
            r_live     <= n_live;
            r_put_id   <= n_put_id;
            r_scan_ptr <= n_scan_ptr;
            r_scan_cnt <= n_scan_cnt;
            r_pend     <= n_pend;
            r_fill     <= n_fill;
            r_status   <= n_status;
            r_stop_v   <= n_stop_v;
            r_stop_id  <= n_stop_id;
            r_disp_v   <= n_disp_v;
            r_disp_id  <= n_disp_id;
        end
    end

endmodule

FILE: sv/round_robin_process_scheduler.sv
// the time from taking a request to its result is set by the sequencer walking the
//   queue ram: one entry per cycle in the duplicate search, the pop, read and check states
//   for each popped ready entry on dispatch, one task per cycle on start; one request at a time
// the result waits in an output register while the next request is taken
// reset: synchronous active low; clears pointers, counts, task state valid bits
//   and the running task, task_count returns to 3; no ram clearing pass
module round_robin_process_scheduler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rrps_pkg::t_in_req  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rrps_pkg::t_out_rsp o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  rrps_pkg::t_cfg     i_cfg_data
);

    rrps_pkg::t_cfg r_task_count;
    logic r_out_valid;
    rrps_pkg::t_out_rsp r_out;

    rrps_pkg::t_tram_req tram_req;
    rrps_pkg::t_qram_req qram_req;
    logic [rrps_pkg::ST_W-1:0] tram_rdata;
    rrps_pkg::t_tid qram_rdata;
    logic seq_done;
    logic done_ready;
    rrps_pkg::t_out_rsp seq_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign done_ready  = !r_out_valid || i_out_ready;

    rrps_ram #(
        .WIDTH (rrps_pkg::ST_W),
        .DEPTH (rrps_pkg::MAX_TASKS)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (tram_req.we),
        .i_waddr (tram_req.waddr),
        .i_wdata (tram_req.wdata),
        .i_raddr (tram_req.raddr),
        .o_rdata (tram_rdata)
    );

    // ready queue in the lower half, blocked queue in the upper half
    rrps_ram #(
        .WIDTH (rrps_pkg::TID_W),
        .DEPTH (rrps_pkg::QRAM_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (qram_req.we),
        .i_waddr (qram_req.waddr),
        .i_wdata (qram_req.wdata),
        .i_raddr (qram_req.raddr),
        .o_rdata (qram_rdata)
    );

    rrps_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_task_count (r_task_count),
        .o_tram       (tram_req),
        .i_tram_rdata (tram_rdata),
        .o_qram       (qram_req),
        .i_qram_rdata (qram_rdata),
        .o_done       (seq_done),
        .i_done_ready (done_ready),
        .o_rsp        (seq_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= rrps_pkg::TASK_COUNT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_task_count <= i_cfg_data;
            end
            if (seq_done && done_ready) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done && done_ready) begin
            r_out <= seq_rsp;
        end
    end

`ifndef SYNTHESIS
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in progress");

    a_dispatch_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.dispatch_valid) |->
        (o_out.running_valid && o_out.running_id == o_out.dispatch_id))
        else $error("dispatched task is not the running task");

    a_idle_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.running_valid) |-> (o_out.running_id == '0))
        else $error("running id nonzero while idle");

    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == rrps_pkg::STAT_IGNORED) |->
        (!o_out.stop_valid && !o_out.dispatch_valid))
        else $error("ignored io completion changed the running task");
`endif

endmodule
